FILE: rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types for the sorted key table
// Beat formats, operation and status codes, cell control codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package skt_pkg;

   // Operation carried by a request beat
   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_LOOKUP = 2'd2,
      FUNC_LIST   = 2'd3
   } func_type;

   // Completion status carried by a response beat
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_DUPLICATE = 3'd1,
      STATUS_NOT_FOUND = 3'd2,
      STATUS_EMPTY     = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      func_type           func;
      logic signed [31:0] key;
      logic [63:0]        payload;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] entry_key;
      logic [63:0]        entry_payload;
      logic               last;
   } rsp_type;

   // Command broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD = 3'd0,
      CELL_CMP  = 3'd1,
      CELL_INS  = 3'd2,
      CELL_DEL  = 3'd3,
      CELL_ROT  = 3'd4
   } cell_op_type;

   // Flags one cell shows its neighbors and the sequencer
   typedef struct packed {
      logic valid; // cell holds an entry
      logic mark;  // cell is empty or its key is above the search key
      logic hit;   // cell holds the search key
   } cell_link_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_CMP  = 2'd1,
      ST_EXEC = 2'd2,
      ST_LIST = 2'd3
   } state_type;

endpackage

FILE: rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key chain
// Holds one key/payload entry and its compare flags. On a broadcast command
// it compares, takes the entry of its lower or upper neighbor, loads the new
// entry, or rotates toward the head for list readout.
// ----------------------------------------------------------------------------
module skt_cell #(
   parameter int PAYLOAD_BITS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  skt_pkg::cell_op_type      cell_op,
   input  logic signed [31:0]        cmd_key,
   input  logic [PAYLOAD_BITS-1:0]   cmd_payload,
   input  skt_pkg::cell_link_type    prev_link,
   input  logic signed [31:0]        prev_key,
   input  logic [PAYLOAD_BITS-1:0]   prev_payload,
   input  skt_pkg::cell_link_type    next_link,
   input  logic signed [31:0]        next_key,
   input  logic [PAYLOAD_BITS-1:0]   next_payload,
   input  logic signed [31:0]        head_key,
   input  logic [PAYLOAD_BITS-1:0]   head_payload,
   output skt_pkg::cell_link_type    link_out,
   output logic signed [31:0]        key_out,
   output logic [PAYLOAD_BITS-1:0]   payload_out
);
   import skt_pkg::*;

   logic                     valid_ff, valid_in;
   logic                     eq_ff, eq_in;
   logic                     gt_ff, gt_in;
   logic signed [31:0]       key_ff, key_in;
   logic [PAYLOAD_BITS-1:0]  payload_ff, payload_in;
   logic                     mark;
   logic                     tail_part;

   // Suffix markers: insert region and delete region
   assign mark      = !valid_ff || gt_ff;
   assign tail_part = valid_ff && (eq_ff || gt_ff);

   assign link_out.valid = valid_ff;
   assign link_out.mark  = mark;
   assign link_out.hit   = valid_ff && eq_ff;
   assign key_out        = key_ff;
   assign payload_out    = payload_ff;

   // Next entry and flags
   always_comb begin
      valid_in   = valid_ff;
      eq_in      = eq_ff;
      gt_in      = gt_ff;
      key_in     = key_ff;
      payload_in = payload_ff;
      case (cell_op)
         CELL_CMP: begin
            eq_in = (key_ff == cmd_key);
            gt_in = (key_ff > cmd_key);
         end
         CELL_INS: begin
            if (mark) begin
               if (prev_link.mark) begin
                  valid_in   = prev_link.valid;
                  key_in     = prev_key;
                  payload_in = prev_payload;
               end else begin
                  valid_in   = 1'b1;
                  key_in     = cmd_key;
                  payload_in = cmd_payload;
               end
            end
         end
         CELL_DEL: begin
            if (tail_part) begin
               valid_in   = next_link.valid;
               key_in     = next_key;
               payload_in = next_payload;
            end
         end
         CELL_ROT: begin
            // valid entries form a ring: the last valid one takes the head
            if (valid_ff) begin
               if (next_link.valid) begin
                  key_in     = next_key;
                  payload_in = next_payload;
               end else begin
                  key_in     = head_key;
                  payload_in = head_payload;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         eq_ff    <= 1'b0;
         gt_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         eq_ff    <= eq_in;
         gt_ff    <= gt_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

endmodule

FILE: rtl/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table: table of unique signed keys kept in ascending order
// The table is a chain of CAPACITY cells, entry 0 at the head, always sorted
// by signed key. Every request beat is registered, compared against all
// cells in the compare state, and executed in the execute state; all cells
// shift together, so an insert or a delete costs no more than a lookup. A
// list request then yields one beat per stored entry: while the response
// side does not stall, the chain rotates one step a cycle past the head
// cell, which drives the response register, and ends in its original order.
// A response stall holds the execute and list steps. A new request is
// taken only when the previous one is done, while its last response beat may
// still sit in the output register. Payloads keep their low PAYLOAD_BITS
// bits and read back zero-extended.
// ----------------------------------------------------------------------------
module sorted_key_table #(
   parameter int CAPACITY     = 16,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  skt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output skt_pkg::rsp_type  rsp_data
);
   import skt_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type                state_ff, state_in;
   req_type                  req_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         remain_ff, remain_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     load_rsp;
   logic                     req_take;
   logic                     out_free;
   cell_op_type              cell_op;

   cell_link_type            link    [CAPACITY];
   logic signed [31:0]       cell_key [CAPACITY];
   logic [PAYLOAD_BITS-1:0]  cell_pay [CAPACITY];

   logic                     any_hit;
   logic signed [31:0]       hit_key;
   logic [PAYLOAD_BITS-1:0]  hit_pay;
   logic                     is_empty;
   logic                     is_full;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_type            p_link, n_link;
      logic signed [31:0]       p_key, n_key;
      logic [PAYLOAD_BITS-1:0]  p_pay, n_pay;

      if (i == 0) begin : g_head
         assign p_link = '0;
         assign p_key  = '0;
         assign p_pay  = '0;
      end else begin : g_mid
         assign p_link = link[i-1];
         assign p_key  = cell_key[i-1];
         assign p_pay  = cell_pay[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign n_link = '0;
         assign n_key  = '0;
         assign n_pay  = '0;
      end else begin : g_body
         assign n_link = link[i+1];
         assign n_key  = cell_key[i+1];
         assign n_pay  = cell_pay[i+1];
      end

      skt_cell #(
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_op      (cell_op),
         .cmd_key      (req_ff.key),
         .cmd_payload  (req_ff.payload[PAYLOAD_BITS-1:0]),
         .prev_link    (p_link),
         .prev_key     (p_key),
         .prev_payload (p_pay),
         .next_link    (n_link),
         .next_key     (n_key),
         .next_payload (n_pay),
         .head_key     (cell_key[0]),
         .head_payload (cell_pay[0]),
         .link_out     (link[i]),
         .key_out      (cell_key[i]),
         .payload_out  (cell_pay[i])
      );
   end

   // Matching entry: at most one cell hits, so an OR of gated entries
   always_comb begin
      any_hit = 1'b0;
      hit_key = '0;
      hit_pay = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         any_hit = any_hit | link[i].hit;
         hit_key = hit_key | (link[i].hit ? cell_key[i] : 32'sd0);
         hit_pay = hit_pay | (link[i].hit ? cell_pay[i] : '0);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_CMP;
         end
         ST_CMP: state_in = ST_EXEC;
         ST_EXEC: begin
            if (out_free) begin
               if (req_ff.func == FUNC_LIST && !is_empty) state_in = ST_LIST;
               else                                       state_in = ST_IDLE;
            end
         end
         ST_LIST: begin
            if (out_free && remain_ff == CNT_W'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: cell command, response load, counters
   always_comb begin
      cell_op   = CELL_HOLD;
      load_rsp  = 1'b0;
      rsp_in    = rsp_ff;
      count_in  = count_ff;
      remain_in = remain_ff;
      case (state_ff)
         ST_CMP: cell_op = CELL_CMP;
         ST_EXEC: begin
            if (out_free) begin
               rsp_in.last          = 1'b1;
               rsp_in.status        = STATUS_OK;
               rsp_in.entry_key     = '0;
               rsp_in.entry_payload = '0;
               case (req_ff.func)
                  FUNC_INSERT: begin
                     load_rsp = 1'b1;
                     if (any_hit) begin
                        rsp_in.status        = STATUS_DUPLICATE;
                        rsp_in.entry_key     = hit_key;
                        rsp_in.entry_payload = 64'(hit_pay);
                     end else if (is_full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        cell_op              = CELL_INS;
                        count_in             = count_ff + CNT_W'(1);
                        rsp_in.entry_key     = req_ff.key;
                        rsp_in.entry_payload = 64'(req_ff.payload[PAYLOAD_BITS-1:0]);
                     end
                  end
                  FUNC_DELETE, FUNC_LOOKUP: begin
                     load_rsp = 1'b1;
                     if (is_empty) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else if (!any_hit) begin
                        rsp_in.status = STATUS_NOT_FOUND;
                     end else begin
                        rsp_in.entry_key     = hit_key;
                        rsp_in.entry_payload = 64'(hit_pay);
                        if (req_ff.func == FUNC_DELETE) begin
                           cell_op  = CELL_DEL;
                           count_in = count_ff - CNT_W'(1);
                        end
                     end
                  end
                  FUNC_LIST: begin
                     if (is_empty) begin
                        load_rsp      = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        remain_in = count_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LIST: begin
            if (out_free) begin
               load_rsp             = 1'b1;
               cell_op              = CELL_ROT;
               remain_in            = remain_ff - CNT_W'(1);
               rsp_in.status        = STATUS_OK;
               rsp_in.entry_key     = cell_key[0];
               rsp_in.entry_payload = 64'(cell_pay[0]);
               rsp_in.last          = (remain_ff == CNT_W'(1));
            end
         end
         default: begin
         end
      endcase
   end

   // Output register: loads a new beat or drains when taken
   always_comb begin
      if (load_rsp)       rsp_valid_in = 1'b1;
      else if (rsp_stall) rsp_valid_in = rsp_valid_ff;
      else                rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) req_ff <= req_data;
      if (load_rsp) rsp_ff <= rsp_in;
   end

endmodule

FILE: rtl/skt_checker.sv
// ----------------------------------------------------------------------------
// skt_checker: port-level checks for the sorted key table
// Watches the top-level ports and flags response beats that break the
// table's rules; bound to every instance of the top level.
// ----------------------------------------------------------------------------
module skt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input skt_pkg::req_type  req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input skt_pkg::rsp_type  rsp_data
);
   import skt_pkg::*;

   // A stalled request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request beat changed while stalled");

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // Only an ok beat can be followed by more beats of the same request
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.last)
      else $error("error status on a non-final beat");

   // Miss, empty and full beats carry no entry
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_NOT_FOUND ||
                    rsp_data.status == STATUS_EMPTY ||
                    rsp_data.status == STATUS_FULL)
      |-> rsp_data.entry_key == 32'sd0 && rsp_data.entry_payload == 64'd0)
      else $error("entry fields not zero on miss, empty or full");

   // Nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat right after reset");

endmodule

bind sorted_key_table skt_checker u_skt_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the sorted key table
// Walks a short table of directed commands (empty table, extreme keys and
// payloads, duplicate, missing key, full table), then runs phases of random
// insert, delete, lookup and list commands that alternate between filling
// and draining the table. Each response beat is checked field by field
// against a local model of the sorted table or a known directed response.
// Both sides idle in random bursts, except in the last part of the run.
// ----------------------------------------------------------------------------
module tb;
   import skt_pkg::*;

   localparam int CAPACITY     = 16;
   localparam int PAYLOAD_BITS = 64;
   localparam int CLK_PERIOD   = 10;
   localparam int RANDOM_ITEMS = 340;
   localparam int QUIET_ITEMS  = 60;
   localparam int PHASE_ITEMS  = 40;
   localparam int POOL_SIZE    = 24;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 1000000;

   localparam logic signed [31:0] MIN_KEY  = 32'sh8000_0000;
   localparam logic signed [31:0] MAX_KEY  = 32'sh7fff_ffff;
   localparam logic [63:0]        ALL_ONES = {64{1'b1}};
   localparam logic [63:0]        PAY_MASK = ALL_ONES >> (64 - PAYLOAD_BITS);

   // One line of the directed command table; reps > 1 repeats the command with
   // consecutive keys and random payloads
   typedef struct {
      func_type           func;
      logic signed [31:0] key;
      logic [63:0]        payload;
      int                 reps;
      bit                 known;
      status_type         status;
      logic signed [31:0] exp_key;
      logic [63:0]        exp_pay;
   } stim_row_type;

   logic     clock     = 1'b0;
   logic     reset     = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   req_type  req_data  = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   rsp_type  rsp_data;

   // Local copy of the sorted table
   logic signed [31:0] tbl_keys[CAPACITY];
   logic [63:0]        tbl_pays[CAPACITY];
   int                 tbl_count = 0;

   rsp_type       expected_rsps[$];
   stim_row_type  stim_rows[$];
   int            mismatch_count = 0;
   int            cycle_count    = 0;
   int            stall_left     = 0;
   bit            idle_on        = 1'b1;
   bit            quiet          = 1'b0;

   sorted_key_table #(
      .CAPACITY     (CAPACITY),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic rsp_type make_rsp(input status_type st, input logic signed [31:0] k,
                                        input logic [63:0] p, input logic lst);
      rsp_type r;
      r.status        = st;
      r.entry_key     = k;
      r.entry_payload = p;
      r.last          = lst;
      return r;
   endfunction

   function automatic stim_row_type plain_row(input func_type f, input logic signed [31:0] k,
                                              input logic [63:0] p, input int reps);
      stim_row_type s;
      s.func    = f;
      s.key     = k;
      s.payload = p;
      s.reps    = reps;
      s.known   = 1'b0;
      s.status  = STATUS_OK;
      s.exp_key = '0;
      s.exp_pay = '0;
      return s;
   endfunction

   function automatic stim_row_type known_row(input func_type f, input logic signed [31:0] k,
                                              input logic [63:0] p, input status_type st,
                                              input logic signed [31:0] ek,
                                              input logic [63:0] ep);
      stim_row_type s;
      s         = plain_row(f, k, p, 1);
      s.known   = 1'b1;
      s.status  = st;
      s.exp_key = ek;
      s.exp_pay = ep;
      return s;
   endfunction

   // Apply one command to the local table and collect the beats it yields
   function automatic void table_apply(input req_type cmd, ref rsp_type outs[$]);
      int          pos;
      int          i;
      bit          hit;
      logic [63:0] pay;
      pay = cmd.payload & PAY_MASK;
      if (cmd.func == FUNC_LIST) begin
         if (tbl_count == 0)
            outs.push_back(make_rsp(STATUS_EMPTY, '0, '0, 1'b1));
         for (i = 0; i < tbl_count; i++)
            outs.push_back(make_rsp(STATUS_OK, tbl_keys[i], tbl_pays[i], i + 1 == tbl_count));
         return;
      end
      // first slot whose key is not below the search key
      pos = 0;
      while (pos < tbl_count && $signed(tbl_keys[pos]) < $signed(cmd.key))
         pos++;
      hit = pos < tbl_count && tbl_keys[pos] == cmd.key;
      if (cmd.func == FUNC_INSERT) begin
         if (hit)
            outs.push_back(make_rsp(STATUS_DUPLICATE, tbl_keys[pos], tbl_pays[pos], 1'b1));
         else if (tbl_count >= CAPACITY)
            outs.push_back(make_rsp(STATUS_FULL, '0, '0, 1'b1));
         else begin
            for (i = tbl_count; i > pos; i--) begin
               tbl_keys[i] = tbl_keys[i - 1];
               tbl_pays[i] = tbl_pays[i - 1];
            end
            tbl_keys[pos] = cmd.key;
            tbl_pays[pos] = pay;
            tbl_count++;
            outs.push_back(make_rsp(STATUS_OK, cmd.key, pay, 1'b1));
         end
      end else if (tbl_count == 0)
         outs.push_back(make_rsp(STATUS_EMPTY, '0, '0, 1'b1));
      else if (!hit)
         outs.push_back(make_rsp(STATUS_NOT_FOUND, '0, '0, 1'b1));
      else begin
         outs.push_back(make_rsp(STATUS_OK, tbl_keys[pos], tbl_pays[pos], 1'b1));
         // delete closes the gap
         if (cmd.func == FUNC_DELETE) begin
            for (i = pos; i + 1 < tbl_count; i++) begin
               tbl_keys[i] = tbl_keys[i + 1];
               tbl_pays[i] = tbl_pays[i + 1];
            end
            tbl_count--;
         end
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Present one request beat, wait for it to be taken, then predict it.
   // A known response, where given, stands in for the predicted one.
   task automatic send_req(input req_type cmd, input bit known, input rsp_type known_rsp);
      rsp_type produced[$];
      if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      table_apply(cmd, produced);
      if (known)
         expected_rsps.push_back(known_rsp);
      else
         expected_rsps = {expected_rsps, produced};
   endtask

   // Response side stalls in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check each accepted response beat against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch($sformatf("unexpected beat status %0d key %0d",
                                      rsp_data.status, rsp_data.entry_key));
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_data.status, want.status));
            if (rsp_data.entry_key !== want.entry_key)
               report_mismatch($sformatf("entry_key %0d, want %0d",
                                         rsp_data.entry_key, want.entry_key));
            if (rsp_data.entry_payload !== want.entry_payload)
               report_mismatch($sformatf("entry_payload %h, want %h",
                                         rsp_data.entry_payload, want.entry_payload));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last %b, want %b", rsp_data.last, want.last));
         end
      end
   end

   // Watchdog
   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      req_type            cmd;
      logic signed [31:0] key_pool[POOL_SIZE];
      int                 r;
      int                 j;
      int                 p;
      int                 sent;
      int                 pick;
      int                 phase;

      // directed commands
      stim_rows.push_back(known_row(FUNC_LIST, '0, '0, STATUS_EMPTY, '0, '0));
      stim_rows.push_back(known_row(FUNC_LOOKUP, 5, '0, STATUS_EMPTY, '0, '0));
      stim_rows.push_back(known_row(FUNC_DELETE, MIN_KEY, '0, STATUS_EMPTY, '0, '0));
      stim_rows.push_back(known_row(FUNC_INSERT, MAX_KEY, ALL_ONES, STATUS_OK, MAX_KEY,
                                    ALL_ONES));
      stim_rows.push_back(known_row(FUNC_INSERT, MIN_KEY, '0, STATUS_OK, MIN_KEY, '0));
      stim_rows.push_back(known_row(FUNC_INSERT, 0, 64'ha5a5_5a5a_0f0f_f0f0, STATUS_OK, 0,
                                    64'ha5a5_5a5a_0f0f_f0f0));
      stim_rows.push_back(known_row(FUNC_INSERT, MAX_KEY, 64'h1234, STATUS_DUPLICATE, MAX_KEY,
                                    ALL_ONES));
      stim_rows.push_back(known_row(FUNC_LOOKUP, -1, '0, STATUS_NOT_FOUND, '0, '0));
      stim_rows.push_back(known_row(FUNC_DELETE, 1, '0, STATUS_NOT_FOUND, '0, '0));
      stim_rows.push_back(known_row(FUNC_LOOKUP, MIN_KEY, '0, STATUS_OK, MIN_KEY, '0));
      stim_rows.push_back(plain_row(FUNC_LIST, '0, '0, 1));
      stim_rows.push_back(known_row(FUNC_DELETE, 0, '0, STATUS_OK, 0,
                                    64'ha5a5_5a5a_0f0f_f0f0));
      stim_rows.push_back(known_row(FUNC_DELETE, MAX_KEY, '0, STATUS_OK, MAX_KEY, ALL_ONES));
      stim_rows.push_back(known_row(FUNC_DELETE, MIN_KEY, '0, STATUS_OK, MIN_KEY, '0));
      stim_rows.push_back(known_row(FUNC_LIST, '0, '0, STATUS_EMPTY, '0, '0));
      // fill the table with keys -8..7, then hit it while full
      stim_rows.push_back(plain_row(FUNC_INSERT, -8, '0, CAPACITY));
      stim_rows.push_back(known_row(FUNC_INSERT, 100, '0, STATUS_FULL, '0, '0));
      stim_rows.push_back(plain_row(FUNC_INSERT, 3, '0, 1));
      stim_rows.push_back(plain_row(FUNC_LIST, '0, '0, 1));
      stim_rows.push_back(plain_row(FUNC_DELETE, -8, '0, 1));
      stim_rows.push_back(plain_row(FUNC_INSERT, MIN_KEY, 64'h0123_4567_89ab_cdef, 1));
      stim_rows.push_back(known_row(FUNC_INSERT, MAX_KEY, ALL_ONES, STATUS_FULL, '0, '0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < stim_rows.size(); r++) begin
         for (j = 0; j < stim_rows[r].reps; j++) begin
            cmd.func    = stim_rows[r].func;
            cmd.key     = stim_rows[r].key + j;
            cmd.payload = stim_rows[r].reps > 1 ? {$urandom, $urandom} : stim_rows[r].payload;
            send_req(cmd, stim_rows[r].known,
                     make_rsp(stim_rows[r].status, stim_rows[r].exp_key, stim_rows[r].exp_pay,
                              1'b1));
         end
      end

      // random phases, alternately filling and draining the table
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         for (p = 0; p < POOL_SIZE; p++) begin
            if ($urandom_range(0, 3) == 0)
               key_pool[p] = $signed($urandom_range(0, 40)) - 20;
            else
               key_pool[p] = $urandom;
         end
         if ($urandom_range(0, 1) == 0)
            key_pool[0] = MIN_KEY;
         if ($urandom_range(0, 1) == 0)
            key_pool[1] = MAX_KEY;
         idle_on = $urandom_range(0, 3) != 0;
         for (j = 0; j < PHASE_ITEMS && sent < RANDOM_ITEMS; j++) begin
            if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
               quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (phase % 2 == 0)
               cmd.func = pick < 60 ? FUNC_INSERT : pick < 75 ? FUNC_DELETE :
                          pick < 92 ? FUNC_LOOKUP : FUNC_LIST;
            else
               cmd.func = pick < 20 ? FUNC_INSERT : pick < 65 ? FUNC_DELETE :
                          pick < 90 ? FUNC_LOOKUP : FUNC_LIST;
            // stored keys, keys from the phase's small pool, and some noise
            pick = $urandom_range(0, 99);
            if (pick < 40 && tbl_count > 0)
               cmd.key = tbl_keys[$urandom_range(0, tbl_count - 1)];
            else if (pick < 80)
               cmd.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
               cmd.key = $urandom;
            cmd.payload = {$urandom, $urandom};
            send_req(cmd, 1'b0, '0);
            sent++;
         end
         phase++;
      end
      req_valid <= 1'b0;

      // drain, then wait for stray beats
      while (expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
